// ===== sv/dtlr_pkg.sv =====
package dtlr_pkg;

   // Depth store geometry
   localparam int DEPTH_SIDE  = 64;
   localparam int STORE_DEPTH = DEPTH_SIDE * DEPTH_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Field widths
   localparam int COORD_W = 12;
   localparam int DEPTH_W = 16;
   localparam int ERR_W   = 14;
   localparam int GLYPH_W = 8;
   localparam int COLOR_W = 4;
   localparam int PIX_W   = 6;
   localparam int CFG_W   = 7;

   // Visible area never exceeds the store nor the pixel field range
   localparam int PIX_LIMIT = 1 << PIX_W;
   localparam int VIS_MAX   = (DEPTH_SIDE < PIX_LIMIT) ? DEPTH_SIDE : PIX_LIMIT;

   // Value of a cleared depth entry: -100.0 in signed Q8.8
   localparam logic signed [DEPTH_W-1:0] CLEAR_DEPTH = DEPTH_W'(-25600);

   // Register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_COLS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_LINES = 1'b1;
   localparam logic [CFG_W-1:0]     SCREEN_RESET     = CFG_W'(64);

   // Item modes
   localparam logic MODE_CLEAR = 1'b0;
   localparam logic MODE_DRAW  = 1'b1;

   // Divider iteration counter
   localparam int DIV_CNT_W = $clog2(DEPTH_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DIVIDE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               start;
      logic [DEPTH_W-1:0] dividend;
      logic [COORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DEPTH_W-1:0] quotient;
      logic [COORD_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== sv/dtlr_div.sv =====
module dtlr_div
   import dtlr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DEPTH_W-1:0]   dvd_ff, dvd_in;
   logic [DEPTH_W-1:0]   quo_ff, quo_in;
   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [COORD_W:0]     trial;
   logic                 fits;

   // Restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[DEPTH_W-1]};
      fits    = trial >= {1'b0, div_req.divisor};
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         quo_in = '0;
         rem_in = '0;
         cnt_in = DIV_CNT_W'(DEPTH_W);
      end else if (cnt_ff != '0) begin
         dvd_in  = {dvd_ff[DEPTH_W-2:0], 1'b0};
         quo_in  = {quo_ff[DEPTH_W-2:0], fits};
         rem_in  = fits ? COORD_W'(trial - {1'b0, div_req.divisor}) : COORD_W'(trial);
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== sv/depth_tested_line_rasterizer.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  mode, endpoints, depths, glyph, color
// rsp      out        rsp_valid / rsp_stall  write, pixel_x/y, glyph_out, color_out, last
// csr      in         csr_valid / csr_ready  csr_index, csr_data (screen_cols, screen_lines)
//
// A draw item divides |dz| by total = max(|dx|,|dy|) in the bit-serial depth divider,
// then takes one Bresenham step per cycle, while rsp is not stalled, through the read
// and write ports of the depth memory, then gives the final result.
// A clear item sweeps the store: the sweep writes one entry per cycle.
// After reset the same sweep runs with req_stall high.
// A stalled rsp holds the walk; csr writes are taken in every cycle.
module depth_tested_line_rasterizer
   import dtlr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic signed [COORD_W-1:0]  req_start_x,
   input  logic signed [COORD_W-1:0]  req_start_y,
   input  logic signed [COORD_W-1:0]  req_end_x,
   input  logic signed [COORD_W-1:0]  req_end_y,
   input  logic signed [DEPTH_W-1:0]  req_start_depth,
   input  logic signed [DEPTH_W-1:0]  req_end_depth,
   input  logic        [GLYPH_W-1:0]  req_glyph,
   input  logic        [COLOR_W-1:0]  req_color,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_write,
   output logic        [PIX_W-1:0]    rsp_pixel_x,
   output logic        [PIX_W-1:0]    rsp_pixel_y,
   output logic        [GLYPH_W-1:0]  rsp_glyph_out,
   output logic        [COLOR_W-1:0]  rsp_color_out,
   output logic                       rsp_last,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [CFG_W-1:0]    csr_data
);

   // Control
   state_type            state_ff, state_in;
   logic                 clr_act, walk_act, fin_act;
   logic                 accept, rsp_free, walk_go;
   logic [CFG_W-1:0]     cols_ff, cols_in, lines_ff, lines_in;
   logic [CFG_W-1:0]     vis_cols, vis_lines;
   logic [ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                 clr_done;
   logic                 clr_item_ff, clr_item_in;
   logic                 div_start_ff, div_start_in;

   // Line setup
   logic signed [COORD_W:0] diff_x, diff_y;
   logic [COORD_W-1:0]   dx_new, dy_new;
   logic signed [DEPTH_W:0] diff_z;
   logic signed [COORD_W-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic signed [DEPTH_W-1:0] z0_ff, z0_in;
   logic [COORD_W-1:0]   dx_ff, dx_in, dy_ff, dy_in, total_ff, total_in;
   logic                 sx_pos_ff, sx_pos_in, sy_pos_ff, sy_pos_in;
   logic                 dz_neg_ff, dz_neg_in;
   logic [DEPTH_W-1:0]   abs_dz_ff, abs_dz_in;
   logic [GLYPH_W-1:0]   glyph_ff, glyph_in;
   logic [COLOR_W-1:0]   color_ff, color_in;

   // Walker (stage A)
   logic signed [COORD_W-1:0] walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic signed [ERR_W-1:0]   walk_err_ff, walk_err_in;
   logic [DEPTH_W-1:0]   walk_q_ff, walk_q_in;
   logic [COORD_W-1:0]   walk_r_ff, walk_r_in;
   logic                 a_live_ff, a_live_in;
   logic                 a_on, a_end;
   logic [ADDR_W-1:0]    a_addr;
   logic signed [DEPTH_W+1:0] q_s, z_wide;
   logic signed [DEPTH_W-1:0] a_z;
   logic signed [ERR_W:0] e2;
   logic                 step_x, step_y;
   logic [ERR_W-1:0]     err_sub, err_add;
   logic [COORD_W:0]     r_sum;
   logic                 r_wrap;

   // Depth test (stage B)
   logic                 b_valid_ff, b_valid_in, b_on_ff, b_on_in;
   logic [ADDR_W-1:0]    b_addr_ff, b_addr_in;
   logic [PIX_W-1:0]     b_x_ff, b_x_in, b_y_ff, b_y_in;
   logic signed [DEPTH_W-1:0] b_z_ff, b_z_in;
   logic                 pass;

   // Pending pixel and result register
   logic                 pend_valid_ff, pend_valid_in;
   logic [PIX_W-1:0]     pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_load;
   logic                 rsp_write_ff, rsp_write_in, rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [GLYPH_W-1:0]   rsp_glyph_ff, rsp_glyph_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;

   // Depth memory
   logic signed [DEPTH_W-1:0] depth_mem [STORE_DEPTH];
   logic signed [DEPTH_W-1:0] rd_data_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr;
   logic signed [DEPTH_W-1:0] mem_wdata;

   div_req_type div_req;
   div_rsp_type div_rsp;

   dtlr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = abs_dz_ff;
   assign div_req.divisor  = total_ff;

   // Decode state
   always_comb begin
      req_stall = 1'b1;
      clr_act   = 1'b0;
      walk_act  = 1'b0;
      fin_act   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_CLEAR:  clr_act   = 1'b1;
         ST_DIVIDE: ;
         ST_WALK:   walk_act  = 1'b1;
         ST_FINISH: fin_act   = 1'b1;
         default:   ;
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign walk_go   = walk_act && rsp_free;
   assign clr_done  = (clr_cnt_ff == ADDR_W'(STORE_DEPTH - 1));
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = (req_mode == MODE_DRAW) ? ST_DIVIDE : ST_CLEAR;
         end
         ST_CLEAR: begin
            if (clr_done) state_in = clr_item_ff ? ST_FINISH : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!a_live_ff && !b_valid_ff) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Screen registers, clipped to the store
   always_comb begin
      cols_in  = (csr_valid && csr_index == REG_SCREEN_COLS)  ? csr_data : cols_ff;
      lines_in = (csr_valid && csr_index == REG_SCREEN_LINES) ? csr_data : lines_ff;
      vis_cols  = (cols_ff  > CFG_W'(VIS_MAX)) ? CFG_W'(VIS_MAX) : cols_ff;
      vis_lines = (lines_ff > CFG_W'(VIS_MAX)) ? CFG_W'(VIS_MAX) : lines_ff;
   end

   // Line setup on accept
   always_comb begin
      diff_x = (COORD_W+1)'(req_end_x) - (COORD_W+1)'(req_start_x);
      diff_y = (COORD_W+1)'(req_end_y) - (COORD_W+1)'(req_start_y);
      diff_z = (DEPTH_W+1)'(req_end_depth) - (DEPTH_W+1)'(req_start_depth);
      dx_new = diff_x[COORD_W] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
      dy_new = diff_y[COORD_W] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
   end

   // Walker: depth, screen test, Bresenham step, incremental quotient
   always_comb begin
      a_on = !walk_x_ff[COORD_W-1] && (unsigned'(walk_x_ff) < COORD_W'(vis_cols)) &&
             !walk_y_ff[COORD_W-1] && (unsigned'(walk_y_ff) < COORD_W'(vis_lines));
      a_addr = ADDR_W'(unsigned'(walk_y_ff)) * ADDR_W'(DEPTH_SIDE) +
               ADDR_W'(unsigned'(walk_x_ff));
      a_end  = (walk_x_ff == x1_ff) && (walk_y_ff == y1_ff);
      q_s    = $signed({2'b00, walk_q_ff});
      z_wide = (DEPTH_W+2)'(z0_ff) + (dz_neg_ff ? -q_s : q_s);
      a_z    = DEPTH_W'(z_wide);

      e2      = {walk_err_ff, 1'b0};
      step_x  = e2 > -$signed((ERR_W+1)'(dy_ff));
      step_y  = e2 <  $signed((ERR_W+1)'(dx_ff));
      err_sub = step_x ? ERR_W'(dy_ff) : '0;
      err_add = step_y ? ERR_W'(dx_ff) : '0;

      r_sum  = (COORD_W+1)'(walk_r_ff) + (COORD_W+1)'(div_rsp.remainder);
      r_wrap = r_sum >= (COORD_W+1)'(total_ff);
   end

   // Datapath next values
   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      clr_item_in  = clr_item_ff;
      div_start_in = 1'b0;
      x1_in = x1_ff;  y1_in = y1_ff;  z0_in = z0_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  total_in = total_ff;
      sx_pos_in = sx_pos_ff;  sy_pos_in = sy_pos_ff;
      dz_neg_in = dz_neg_ff;  abs_dz_in = abs_dz_ff;
      glyph_in  = glyph_ff;   color_in  = color_ff;
      walk_x_in = walk_x_ff;  walk_y_in = walk_y_ff;  walk_err_in = walk_err_ff;
      walk_q_in = walk_q_ff;  walk_r_in = walk_r_ff;  a_live_in = a_live_ff;
      b_valid_in = b_valid_ff;  b_on_in = b_on_ff;  b_addr_in = b_addr_ff;
      b_x_in = b_x_ff;  b_y_in = b_y_ff;  b_z_in = b_z_ff;
      pend_valid_in = pend_valid_ff;  pend_x_in = pend_x_ff;  pend_y_in = pend_y_ff;

      // Advance clear sweep
      if (clr_act) clr_cnt_in = clr_cnt_ff + ADDR_W'(1);

      // Take a new item
      if (accept) begin
         pend_valid_in = 1'b0;
         if (req_mode == MODE_DRAW) begin
            x1_in        = req_end_x;
            y1_in        = req_end_y;
            z0_in        = req_start_depth;
            dx_in        = dx_new;
            dy_in        = dy_new;
            total_in     = (dx_new > dy_new) ? dx_new : dy_new;
            sx_pos_in    = req_start_x < req_end_x;
            sy_pos_in    = req_start_y < req_end_y;
            dz_neg_in    = diff_z[DEPTH_W];
            abs_dz_in    = diff_z[DEPTH_W] ? DEPTH_W'(-diff_z) : DEPTH_W'(diff_z);
            glyph_in     = req_glyph;
            color_in     = req_color;
            walk_x_in    = req_start_x;
            walk_y_in    = req_start_y;
            walk_err_in  = $signed(ERR_W'(dx_new)) - $signed(ERR_W'(dy_new));
            walk_q_in    = '0;
            walk_r_in    = '0;
            a_live_in    = 1'b1;
            div_start_in = 1'b1;
         end else begin
            clr_cnt_in  = '0;
            clr_item_in = 1'b1;
         end
      end

      if (walk_go) begin
         // Move stage A into stage B, step the walker
         b_valid_in = a_live_ff;
         b_on_in    = a_on;
         b_addr_in  = a_addr;
         b_x_in     = walk_x_ff[PIX_W-1:0];
         b_y_in     = walk_y_ff[PIX_W-1:0];
         b_z_in     = a_z;
         if (a_live_ff) begin
            if (a_end) begin
               a_live_in = 1'b0;
            end else begin
               walk_err_in = walk_err_ff - err_sub + err_add;
               if (step_x) walk_x_in = sx_pos_ff ? walk_x_ff + COORD_W'(1)
                                                 : walk_x_ff - COORD_W'(1);
               if (step_y) walk_y_in = sy_pos_ff ? walk_y_ff + COORD_W'(1)
                                                 : walk_y_ff - COORD_W'(1);
               walk_r_in = r_wrap ? COORD_W'(r_sum - (COORD_W+1)'(total_ff))
                                  : COORD_W'(r_sum);
               walk_q_in = walk_q_ff + div_rsp.quotient + DEPTH_W'(r_wrap);
            end
         end
         // Park a passing pixel until it is known whether it is the last
         if (b_valid_ff && pass) begin
            pend_valid_in = 1'b1;
            pend_x_in     = b_x_ff;
            pend_y_in     = b_y_ff;
         end
      end
   end

   // Depth test against the registered read data
   assign pass = b_on_ff && (b_z_ff > rd_data_ff);

   // Result register
   always_comb begin
      rsp_load     = 1'b0;
      rsp_write_in = rsp_write_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (walk_go && b_valid_ff && pass && pend_valid_ff) begin
         // Release the previous pixel, another one follows
         rsp_load     = 1'b1;
         rsp_write_in = 1'b1;
         rsp_x_in     = pend_x_ff;
         rsp_y_in     = pend_y_ff;
         rsp_glyph_in = glyph_ff;
         rsp_color_in = color_ff;
         rsp_last_in  = 1'b0;
      end else if (fin_act && rsp_free) begin
         // Close the item: last pixel, or the empty marker
         rsp_load     = 1'b1;
         rsp_write_in = pend_valid_ff;
         rsp_x_in     = pend_valid_ff ? pend_x_ff : '0;
         rsp_y_in     = pend_valid_ff ? pend_y_ff : '0;
         rsp_glyph_in = pend_valid_ff ? glyph_ff  : '0;
         rsp_color_in = pend_valid_ff ? color_ff  : '0;
         rsp_last_in  = 1'b1;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_free ? 1'b0 : rsp_valid_ff);
   end

   // Memory port selection
   always_comb begin
      mem_re    = walk_go && a_live_ff && a_on;
      mem_we    = 1'b0;
      mem_waddr = b_addr_ff;
      mem_wdata = b_z_ff;
      if (clr_act) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = CLEAR_DEPTH;
      end else if (walk_go && b_valid_ff && pass) begin
         mem_we = 1'b1;
      end
   end

   // Depth memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) rd_data_ff <= depth_mem[a_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         clr_item_ff   <= 1'b0;
         cols_ff       <= SCREEN_RESET;
         lines_ff      <= SCREEN_RESET;
         div_start_ff  <= 1'b0;
         a_live_ff     <= 1'b0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_item_ff   <= clr_item_in;
         cols_ff       <= cols_in;
         lines_ff      <= lines_in;
         div_start_ff  <= div_start_in;
         a_live_ff     <= a_live_in;
         b_valid_ff    <= b_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      z0_ff        <= z0_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      total_ff     <= total_in;
      sx_pos_ff    <= sx_pos_in;
      sy_pos_ff    <= sy_pos_in;
      dz_neg_ff    <= dz_neg_in;
      abs_dz_ff    <= abs_dz_in;
      glyph_ff     <= glyph_in;
      color_ff     <= color_in;
      walk_x_ff    <= walk_x_in;
      walk_y_ff    <= walk_y_in;
      walk_err_ff  <= walk_err_in;
      walk_q_ff    <= walk_q_in;
      walk_r_ff    <= walk_r_in;
      b_on_ff      <= b_on_in;
      b_addr_ff    <= b_addr_in;
      b_x_ff       <= b_x_in;
      b_y_ff       <= b_y_in;
      b_z_ff       <= b_z_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      rsp_write_ff <= rsp_write_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_write     = rsp_write_ff;
   assign rsp_pixel_x   = rsp_x_ff;
   assign rsp_pixel_y   = rsp_y_ff;
   assign rsp_glyph_out = rsp_glyph_ff;
   assign rsp_color_out = rsp_color_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== sv/dtlr_checker.sv =====
module dtlr_checker
   import dtlr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_write,
   input logic [PIX_W-1:0]   rsp_pixel_x,
   input logic [PIX_W-1:0]   rsp_pixel_y,
   input logic [GLYPH_W-1:0] rsp_glyph_out,
   input logic [COLOR_W-1:0] rsp_color_out,
   input logic               rsp_last
);

   // Hold a stalled result
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_write, rsp_pixel_x, rsp_pixel_y, rsp_glyph_out, rsp_color_out, rsp_last}))
      else $error("stalled result changed");

   // Empty marker closes its item and carries zero fields
   marker_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write |-> rsp_last && rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
         rsp_glyph_out == '0 && rsp_color_out == '0)
      else $error("malformed end marker");

   // One item at a time: busy right after an accept
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // Clearing pass follows reset, with no result
   clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("not clearing after reset");

endmodule

bind depth_tested_line_rasterizer dtlr_checker u_dtlr_checker (.*);

// ===== tb/depth_tested_line_rasterizer_tb.sv =====
module depth_tested_line_rasterizer_tb;
   import dtlr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PIXELS    = 64;
   localparam int SETTLE_CYCLES = 32;
   localparam int LONG_HOLD     = 600;
   localparam int CYCLE_LIMIT   = 2000000;

   // One draw or clear item as offered on the req channel
   typedef struct {
      logic                      mode;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [DEPTH_W-1:0] z0;
      logic signed [DEPTH_W-1:0] z1;
      logic [GLYPH_W-1:0]        glyph;
      logic [COLOR_W-1:0]        color;
   } line_item_t;

   // One result as seen on the rsp channel
   typedef struct packed {
      logic               write;
      logic [PIX_W-1:0]   px;
      logic [PIX_W-1:0]   py;
      logic [GLYPH_W-1:0] glyph;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pix_rsp_t;

   // Directed row: the expected result is given only where it is obvious
   typedef struct {
      line_item_t item;
      bit         known;
      pix_rsp_t   result;
   } dir_row_t;

   localparam pix_rsp_t NO_DRAW = '{write: 1'b0, px: '0, py: '0, glyph: '0, color: '0,
                                    last: 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = 1'b0;
   logic signed [COORD_W-1:0] req_start_x = '0;
   logic signed [COORD_W-1:0] req_start_y = '0;
   logic signed [COORD_W-1:0] req_end_x = '0;
   logic signed [COORD_W-1:0] req_end_y = '0;
   logic signed [DEPTH_W-1:0] req_start_depth = '0;
   logic signed [DEPTH_W-1:0] req_end_depth = '0;
   logic [GLYPH_W-1:0]        req_glyph = '0;
   logic [COLOR_W-1:0]        req_color = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_write;
   logic [PIX_W-1:0]          rsp_pixel_x;
   logic [PIX_W-1:0]          rsp_pixel_y;
   logic [GLYPH_W-1:0]        rsp_glyph_out;
   logic [COLOR_W-1:0]        rsp_color_out;
   logic                      rsp_last;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CFG_W-1:0]          csr_data = '0;

   // Mirror of the block state
   logic signed [DEPTH_W-1:0] depth_mirror [STORE_DEPTH];
   int                        scr_cols;
   int                        scr_lines;

   pix_rsp_t pending_px [$];
   dir_row_t dir_rows [$];

   int  snd_idle_pct = 0;
   int  rcv_idle_pct = 0;
   bit  long_hold_req = 1'b0;
   int  fail_count = 0;
   int  items_sent = 0;
   int  clears_sent = 0;
   int  pixels_seen = 0;
   int  markers_seen = 0;
   int  cycle_count = 0;

   depth_tested_line_rasterizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_start_depth (req_start_depth),
      .req_end_depth   (req_end_depth),
      .req_glyph       (req_glyph),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write       (rsp_write),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_glyph_out   (rsp_glyph_out),
      .rsp_color_out   (rsp_color_out),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic line_item_t line_item(logic mode, int x0, int y0, int x1, int y1,
                                            int z0, int z1, int g, int c);
      line_item_t it;
      it.mode  = mode;
      it.x0    = COORD_W'(x0);
      it.y0    = COORD_W'(y0);
      it.x1    = COORD_W'(x1);
      it.y1    = COORD_W'(y1);
      it.z0    = DEPTH_W'(z0);
      it.z1    = DEPTH_W'(z1);
      it.glyph = GLYPH_W'(g);
      it.color = COLOR_W'(c);
      return it;
   endfunction

   function automatic pix_rsp_t drawn_px(int x, int y, int g, int c);
      pix_rsp_t p;
      p.write = 1'b1;
      p.px    = PIX_W'(x);
      p.py    = PIX_W'(y);
      p.glyph = GLYPH_W'(g);
      p.color = COLOR_W'(c);
      p.last  = 1'b1;
      return p;
   endfunction

   // Clear the depth mirror, or walk the line against it and collect the pixels that pass
   task automatic rasterize(input line_item_t it, output pix_rsp_t res[$]);
      int       cx, cy, tx, ty, ddx, ddy, sx, sy, err, e2, total, step, vis_w, vis_h, idx;
      longint   z, dz;
      pix_rsp_t p;
      res = {};
      if (it.mode == MODE_CLEAR) begin
         foreach (depth_mirror[i]) depth_mirror[i] = CLEAR_DEPTH;
      end else begin
         vis_w = (scr_cols > VIS_MAX) ? VIS_MAX : scr_cols;
         vis_h = (scr_lines > VIS_MAX) ? VIS_MAX : scr_lines;
         cx    = it.x0;
         cy    = it.y0;
         tx    = it.x1;
         ty    = it.y1;
         ddx   = (tx > cx) ? tx - cx : cx - tx;
         ddy   = (ty > cy) ? ty - cy : cy - ty;
         sx    = (cx < tx) ? 1 : -1;
         sy    = (cy < ty) ? 1 : -1;
         err   = ddx - ddy;
         total = (ddx > ddy) ? ddx : ddy;
         dz    = longint'(it.z1) - longint'(it.z0);
         step  = 0;
         forever begin
            if (cx >= 0 && cx < vis_w && cy >= 0 && cy < vis_h) begin
               // depth interpolated with truncation toward zero
               z = it.z0;
               if (total > 0) z += (longint'(step) * dz) / total;
               idx = cy * DEPTH_SIDE + cx;
               if (z > depth_mirror[idx]) begin
                  depth_mirror[idx] = z[DEPTH_W-1:0];
                  if (res.size() < MAX_PIXELS) begin
                     p       = drawn_px(cx, cy, it.glyph, it.color);
                     p.last  = 1'b0;
                     res.push_back(p);
                  end
               end
            end
            if (cx == tx && cy == ty) break;
            e2 = 2 * err;
            if (e2 > -ddy) begin
               err -= ddy;
               cx  += sx;
            end
            if (e2 < ddx) begin
               err += ddx;
               cy  += sy;
            end
            step++;
         end
      end
      // flag the final result, or stand in a marker when nothing was drawn
      if (res.size() == 0) res.push_back(NO_DRAW);
      else res[res.size()-1].last = 1'b1;
   endtask

   // Draw a random item: mostly short lines around the screen, some clears and long lines
   function automatic line_item_t random_line();
      int         pick;
      line_item_t it;
      pick    = $urandom_range(99);
      it.mode = (pick < 5) ? MODE_CLEAR : MODE_DRAW;
      if (pick < 8) begin
         it.x0 = COORD_W'($urandom);
         it.y0 = COORD_W'($urandom);
         it.x1 = COORD_W'($urandom);
         it.y1 = COORD_W'($urandom);
      end else begin
         it.x0 = COORD_W'(int'($urandom_range(95)) - 16);
         it.y0 = COORD_W'(int'($urandom_range(95)) - 16);
         it.x1 = COORD_W'(int'($urandom_range(95)) - 16);
         it.y1 = COORD_W'(int'($urandom_range(95)) - 16);
         case ($urandom_range(7))
            0: begin
               it.x1 = it.x0;
            end
            1: begin
               it.y1 = it.y0;
            end
            2: begin
               it.x1 = it.x0;
               it.y1 = it.y0;
            end
            default: begin
            end
         endcase
      end
      it.z0    = DEPTH_W'($urandom);
      it.z1    = DEPTH_W'($urandom);
      it.glyph = GLYPH_W'($urandom);
      it.color = COLOR_W'($urandom);
      return it;
   endfunction

   // Offer one item, record what it should produce, then maybe idle
   task automatic offer(input line_item_t it, input bit known, input pix_rsp_t known_rsp);
      pix_rsp_t res[$];
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_start_x     <= it.x0;
      req_start_y     <= it.y0;
      req_end_x       <= it.x1;
      req_end_y       <= it.y1;
      req_start_depth <= it.z0;
      req_end_depth   <= it.z1;
      req_glyph       <= it.glyph;
      req_color       <= it.color;
      do @(posedge clock); while (req_stall);
      rasterize(it, res);
      if (known) begin
         res = {};
         res.push_back(known_rsp);
      end
      foreach (res[i]) pending_px.push_back(res[i]);
      items_sent++;
      if (it.mode == MODE_CLEAR) clears_sent++;
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
   endtask

   task automatic run_random(input int count);
      repeat (count) offer(random_line(), 1'b0, NO_DRAW);
   endtask

   // Hold the sender until every expected result is in and the block settles
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both screen registers back to back
   task automatic set_screen(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] lines);
      csr_valid <= 1'b1;
      csr_index <= REG_SCREEN_COLS;
      csr_data  <= cols;
      do @(posedge clock); while (!csr_ready);
      scr_cols  = cols;
      csr_index <= REG_SCREEN_LINES;
      csr_data  <= lines;
      do @(posedge clock); while (!csr_ready);
      scr_lines = lines;
      csr_valid <= 1'b0;
   endtask

   // Check accepted results and drive the receiver stall
   initial begin
      pix_rsp_t exp_px;
      int       hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (rsp_write) pixels_seen++;
            else markers_seen++;
            if (pending_px.size() == 0) begin
               $error("unexpected result: write=%0d x=%0d y=%0d last=%0d",
                      rsp_write, rsp_pixel_x, rsp_pixel_y, rsp_last);
               fail_count++;
            end else begin
               exp_px = pending_px.pop_front();
               if (rsp_write !== exp_px.write) begin
                  $error("write: expected %0d, got %0d", exp_px.write, rsp_write);
                  fail_count++;
               end
               if (rsp_pixel_x !== exp_px.px) begin
                  $error("pixel_x: expected %0d, got %0d", exp_px.px, rsp_pixel_x);
                  fail_count++;
               end
               if (rsp_pixel_y !== exp_px.py) begin
                  $error("pixel_y: expected %0d, got %0d", exp_px.py, rsp_pixel_y);
                  fail_count++;
               end
               if (rsp_glyph_out !== exp_px.glyph) begin
                  $error("glyph_out: expected %0d, got %0d", exp_px.glyph, rsp_glyph_out);
                  fail_count++;
               end
               if (rsp_color_out !== exp_px.color) begin
                  $error("color_out: expected %0d, got %0d", exp_px.color, rsp_color_out);
                  fail_count++;
               end
               if (rsp_last !== exp_px.last) begin
                  $error("last: expected %0d, got %0d", exp_px.last, rsp_last);
                  fail_count++;
               end
            end
         end
         // long hold-off when asked, random stalls otherwise
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   initial begin
      scr_cols  = SCREEN_RESET;
      scr_lines = SCREEN_RESET;
      foreach (depth_mirror[i]) depth_mirror[i] = CLEAR_DEPTH;

      // points at the corners and depth limits, then lines in every direction
      dir_rows.push_back('{line_item(MODE_DRAW, 0, 0, 0, 0, 0, 0, 'h41, 1), 1'b1,
                           drawn_px(0, 0, 'h41, 1)});
      dir_rows.push_back('{line_item(MODE_DRAW, 0, 0, 0, 0, 0, 0, 'h42, 2), 1'b1, NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 63, 63, 63, 63, 32767, 32767, 255, 9), 1'b1,
                           drawn_px(63, 63, 255, 9)});
      dir_rows.push_back('{line_item(MODE_DRAW, 5, 5, 5, 5, -32768, -32768, 3, 3), 1'b1,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 5, 5, 5, 5, -25600, -25600, 4, 4), 1'b1,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 5, 5, 5, 5, -25599, -25599, 5, 5), 1'b1,
                           drawn_px(5, 5, 5, 5)});
      dir_rows.push_back('{line_item(MODE_DRAW, -2048, -2048, -2048, -2048, 100, 100, 6, 6),
                           1'b1, NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 2047, 2047, 2047, 2047, 100, 100, 7, 7), 1'b1,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 64, 10, 64, 10, 100, 100, 8, 8), 1'b1,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 10, -1, 10, -1, 100, 100, 8, 8), 1'b1,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, -2048, -2048, 2047, 2047, -32768, 32767,
                                     'h2A, 15), 1'b0, NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 0, 10, 63, 10, 256, 512, 'h2D, 0), 1'b0,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 20, 63, 20, 0, 1000, -1000, 'h7C, 2), 1'b0,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 3, 0, 10, 60, -500, 700, 'h2F, 3), 1'b0,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 60, 40, 2, 30, 2000, 1500, 'h5C, 4), 1'b0,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, -30, -10, 40, 50, 5000, 5000, 'h23, 5), 1'b0,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, -30, -10, 40, 50, 4000, 6000, 'h40, 6), 1'b0,
                           NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, -1984, 2047, 2047, -1984, 300, -300, 'h78, 7),
                           1'b0, NO_DRAW});
      dir_rows.push_back('{line_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 7, 7, 7, 7, 100, -30000, 'h2B, 8), 1'b1,
                           drawn_px(7, 7, 'h2B, 8)});
      dir_rows.push_back('{line_item(MODE_DRAW, 0, 0, 63, 0, 0, 0, 0, 1), 1'b0, NO_DRAW});
      dir_rows.push_back('{line_item(MODE_DRAW, 10, 10, 11, 11, -32768, 32767, 'h6F, 9),
                           1'b0, NO_DRAW});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset screen size
      snd_idle_pct = 16;
      rcv_idle_pct = 88;
      foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].known, dir_rows[i].result);

      // largest register values, clipped to the store
      drain();
      set_screen(7'd127, 7'd127);
      run_random(50);

      // no visible cell at all
      drain();
      snd_idle_pct = 88;
      rcv_idle_pct = 16;
      set_screen(7'd0, 7'd0);
      run_random(15);

      // single visible cell
      drain();
      set_screen(7'd1, 7'd1);
      run_random(25);

      // odd screen size, with a full pause halfway
      drain();
      set_screen(CFG_W'($urandom_range(1, 63)), CFG_W'($urandom_range(1, 63)));
      run_random(25);
      drain();
      run_random(25);

      // just above the store size; receiver holds off while the sender keeps pushing
      drain();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      set_screen(7'd65, 7'd64);
      long_hold_req = 1'b1;
      run_random(60);

      // any register values
      drain();
      set_screen(CFG_W'($urandom_range(127)), CFG_W'($urandom_range(127)));
      run_random(50);

      drain();
      repeat (64) @(posedge clock);

      $display("Covered %0d items (%0d clears) over seven screen sizes,", items_sent,
               clears_sent);
      $display("  with %0d drawn pixels and %0d empty markers checked.", pixels_seen,
               markers_seen);
      if (fail_count == 0 && pending_px.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
